FILE: hw/rtl/f2p_pkg.sv
// Shared types and constants for the float-to-PCM converter.
// No dependencies; the stage modules and the top level import this package.
package f2p_pkg;

  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_S8  = 3'd1;
  localparam logic [2:0] FMT_U16 = 3'd2;
  localparam logic [2:0] FMT_S16 = 3'd3;
  localparam logic [2:0] FMT_U32 = 3'd4;
  localparam logic [2:0] FMT_S32 = 3'd5;

  localparam logic [7:0] REG_FORMAT = 8'd0;
  localparam logic [7:0] REG_SWAP   = 8'd1;

  localparam logic [22:0] SCALE_32   = 23'h7F_FFFF;
  localparam logic [7:0]  EXP_ONE    = 8'd127;
  localparam logic [7:0]  EXP_UNITY  = 8'd119;
  localparam logic [24:0] LIM_32_POS = 25'd16777214;

  typedef struct packed {
    logic        neg;
    logic [7:0]  exp;
    logic [23:0] man;
    logic [46:0] prod;
    logic [2:0]  fmt;
    logic        swap;
    logic        eob;
  } s1_t;

  typedef struct packed {
    logic        neg;
    logic        sat;
    logic        zero;
    logic [31:0] q;
    logic [4:0]  sh;
    logic [2:0]  fmt;
    logic        swap;
    logic        eob;
  } s2_t;

  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [31:0] mag;
    logic [2:0]  fmt;
    logic        swap;
    logic        eob;
  } s3_t;

endpackage

FILE: hw/rtl/f2p_in_if.sv
// Input item channel: valid/ready with the float sample payload.
// No dependencies.
interface f2p_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_bits;
  logic        end_of_block;
  modport source (output valid, sample_bits, end_of_block, input ready);
  modport sink   (input valid, sample_bits, end_of_block, output ready);
endinterface

FILE: hw/rtl/f2p_out_if.sv
// Result item channel: valid/ready with the PCM word payload.
// No dependencies.
interface f2p_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pcm_word;
  logic        block_end;
  modport source (output valid, pcm_word, block_end, input ready);
  modport sink   (input valid, pcm_word, block_end, output ready);
endinterface

FILE: hw/rtl/f2p_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// No dependencies.
interface f2p_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/f2p_decode.sv
// Stage 1: NaN cleanup, field split and significand times (2^23-1).
// Depends on f2p_pkg.
module f2p_decode (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       sample_bits,
  input  logic              end_of_block,
  input  logic [2:0]        fmt,
  input  logic              swap,
  output f2p_pkg::s1_t      s1_r
);
  import f2p_pkg::*;

  logic [31:0] clean;
  logic [23:0] man;
  s1_t         s1_nxt;

  always_comb begin
    clean = sample_bits;
    if ((&sample_bits[30:23]) && (|sample_bits[22:0])) begin
      clean = 32'd0;
    end
    man = {|clean[30:23], clean[22:0]};
    s1_nxt.neg  = clean[31];
    s1_nxt.exp  = clean[30:23];
    s1_nxt.man  = man;
    s1_nxt.prod = 47'(man) * 47'(SCALE_32);
    s1_nxt.fmt  = fmt;
    s1_nxt.swap = swap;
    s1_nxt.eob  = end_of_block;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end
endmodule

FILE: hw/rtl/f2p_align.sv
// Stage 2: single-precision rounding of the 47-bit product on the 32-bit
// path, saturation detection and shift amounts for both paths. Depends on f2p_pkg.
module f2p_align (
  input  logic         clk,
  input  logic         en,
  input  f2p_pkg::s1_t s1,
  output f2p_pkg::s2_t s2_r
);
  import f2p_pkg::*;

  s2_t              s2_nxt;
  logic [24:0]      rsig;
  logic             rup;
  logic signed [9:0] sf;
  logic [7:0]       lsh;

  always_comb begin
    s2_nxt.neg  = s1.neg;
    s2_nxt.fmt  = s1.fmt;
    s2_nxt.swap = s1.swap;
    s2_nxt.eob  = s1.eob;
    s2_nxt.sat  = 1'b0;
    s2_nxt.zero = 1'b0;
    s2_nxt.q    = 32'd0;
    s2_nxt.sh   = 5'd0;
    rsig = 25'd0;
    rup  = 1'b0;
    sf   = 10'sd0;
    lsh  = 8'd0;
    if (s1.fmt[2]) begin
      if (s1.prod[46]) begin
        rup  = s1.prod[22] && ((|s1.prod[21:0]) || s1.prod[23]);
        rsig = {1'b0, s1.prod[46:23]} + 25'(rup);
        sf   = 10'sd127 - signed'({2'b00, s1.exp});
      end else begin
        rup  = s1.prod[21] && ((|s1.prod[20:0]) || s1.prod[22]);
        rsig = {1'b0, s1.prod[45:22]} + 25'(rup);
        sf   = 10'sd128 - signed'({2'b00, s1.exp});
      end
      s2_nxt.q = {7'd0, rsig};
      if (sf <= 10'sd0) begin
        s2_nxt.sat = 1'b1;
      end else if (sf == 10'sd1) begin
        s2_nxt.sat = s1.neg ? rsig[24] : (rsig >= LIM_32_POS);
        s2_nxt.sh  = 5'd1;
      end else if (sf > 10'sd31) begin
        s2_nxt.zero = 1'b1;
      end else begin
        s2_nxt.sh = sf[4:0];
      end
    end else begin
      if (s1.exp >= EXP_ONE) begin
        s2_nxt.sat = 1'b1;
      end else if (s1.exp >= EXP_UNITY) begin
        lsh      = s1.exp - EXP_UNITY;
        s2_nxt.q = {8'd0, s1.man} << lsh[2:0];
      end else begin
        lsh      = EXP_UNITY - s1.exp;
        s2_nxt.q = {8'd0, s1.man};
        if (lsh > 8'd31) begin
          s2_nxt.zero = 1'b1;
        end else begin
          s2_nxt.sh = lsh[4:0];
        end
      end
    end
    if (s1.exp == 8'd0) begin
      s2_nxt.zero = 1'b1;
      s2_nxt.sat  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end
endmodule

FILE: hw/rtl/f2p_round.sv
// Stage 3: right shift with round to nearest, ties to even.
// Depends on f2p_pkg.
module f2p_round (
  input  logic         clk,
  input  logic         en,
  input  f2p_pkg::s2_t s2,
  output f2p_pkg::s3_t s3_r
);
  import f2p_pkg::*;

  s3_t         s3_nxt;
  logic [63:0] ext;
  logic        up;

  always_comb begin
    ext = {s2.q, 32'd0} >> s2.sh;
    up  = ext[31] && ((|ext[30:0]) || ext[32]);
    s3_nxt.neg  = s2.neg;
    s3_nxt.sat  = s2.sat;
    s3_nxt.mag  = s2.zero ? 32'd0 : (ext[63:32] + 32'(up));
    s3_nxt.fmt  = s2.fmt;
    s3_nxt.swap = s2.swap;
    s3_nxt.eob  = s2.eob;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end
endmodule

FILE: hw/rtl/f2p_pack.sv
// Stage 4: sign, saturation, format select, offset and byte swap; output
// register. Depends on f2p_pkg.
module f2p_pack (
  input  logic         clk,
  input  logic         en,
  input  f2p_pkg::s3_t s3,
  output logic [31:0]  pcm_word_r,
  output logic         block_end_r
);
  import f2p_pkg::*;

  logic [31:0] w;
  logic [31:0] w16;
  logic [23:0] w24;
  logic [15:0] h;
  logic [31:0] word;
  logic [31:0] pcm_word_nxt;

  always_comb begin
    w   = s3.neg ? (32'd0 - s3.mag) : s3.mag;
    w16 = s3.sat ? (s3.neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : w;
    w24 = s3.sat ? (s3.neg ? 24'h80_0000 : 24'h7F_FFFF) : w[23:0];
    h    = 16'd0;
    word = 32'd0;
    case (s3.fmt)
      FMT_U8:  pcm_word_nxt = {24'd0, w16[31:24] ^ 8'h80};
      FMT_S8:  pcm_word_nxt = {24'd0, w16[31:24]};
      FMT_U16, FMT_S16: begin
        h = w16[31:16] ^ {(s3.fmt == FMT_U16), 15'd0};
        pcm_word_nxt = s3.swap ? {16'd0, h[7:0], h[15:8]} : {16'd0, h};
      end
      FMT_U32, FMT_S32: begin
        word = {w24 ^ {(s3.fmt == FMT_U32), 23'd0}, 8'd0};
        pcm_word_nxt = s3.swap ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
      end
      default: pcm_word_nxt = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcm_word_r  <= pcm_word_nxt;
      block_end_r <= s3.eob;
    end
  end
endmodule

FILE: hw/rtl/float_to_pcm_fixed_converter_core.sv
// Top level of the float-to-PCM converter: config registers, valid chain
// and the four pipeline stages. Depends on f2p_pkg, the channel interfaces
// and f2p_decode, f2p_align, f2p_round, f2p_pack.
//
//   channel   dir  payload
//   in_chan   in   sample_bits[31:0], end_of_block
//   out_chan  out  pcm_word[31:0], block_end
//   cfg_chan  in   index[7:0], data[31:0] (always ready)
//
// One item per cycle is sustained while out_chan is ready. All stages advance
// together when the output register is empty or taken, so a stall freezes the
// whole pipeline in place.
// Reset clears the valid chain and sets format s16, no byte swap.
module float_to_pcm_fixed_converter_core (
  input  logic   clk,
  input  logic   rst_n,
  f2p_in_if.sink    in_chan,
  f2p_out_if.source out_chan,
  f2p_cfg_if.sink   cfg_chan
);
  import f2p_pkg::*;

  logic [2:0] fmt_r;
  logic       swap_r;
  logic       v1_r, v2_r, v3_r, v4_r;
  logic       adv;
  s1_t        s1_r;
  s2_t        s2_r;
  s3_t        s3_r;

  assign adv            = !v4_r || out_chan.ready;
  assign in_chan.ready  = adv;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FMT_S16;
      swap_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == REG_FORMAT) begin
        fmt_r <= cfg_chan.data[2:0];
      end else if (cfg_chan.index == REG_SWAP) begin
        swap_r <= cfg_chan.data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_chan.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  f2p_decode u_decode (
    .clk          (clk),
    .en           (adv),
    .sample_bits  (in_chan.sample_bits),
    .end_of_block (in_chan.end_of_block),
    .fmt          (fmt_r),
    .swap         (swap_r),
    .s1_r         (s1_r)
  );

  f2p_align u_align (
    .clk  (clk),
    .en   (adv),
    .s1   (s1_r),
    .s2_r (s2_r)
  );

  f2p_round u_round (
    .clk  (clk),
    .en   (adv),
    .s2   (s2_r),
    .s3_r (s3_r)
  );

  f2p_pack u_pack (
    .clk         (clk),
    .en          (adv),
    .s3          (s3_r),
    .pcm_word_r  (out_chan.pcm_word),
    .block_end_r (out_chan.block_end)
  );

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !adv) |=> (v2_r && $stable(s2_r)))
    else $error("stage 2 item lost during stall");

  a_width8: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && adv && (s3_r.fmt == FMT_U8 || s3_r.fmt == FMT_S8))
      |=> (out_chan.pcm_word[31:8] == 24'd0))
    else $error("8-bit item has upper bits set");

  a_width16: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && adv && (s3_r.fmt == FMT_U16 || s3_r.fmt == FMT_S16))
      |=> (out_chan.pcm_word[31:16] == 16'd0))
    else $error("16-bit item has upper bits set");
endmodule
